// ===== rtl/np_pkg.sv =====
`default_nettype none
package np_pkg;

    localparam int MAX_LEN   = 8;
    localparam int NUM_BYTES = 8;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = $clog2(NUM_BYTES);
    localparam int S_DATA_W  = ((NUM_BYTES * BYTE_W + LEN_W + 7) / 8) * 8;
    localparam int M_DATA_W  = NUM_BYTES * BYTE_W;

    // Effective length bound, never above the number of byte fields
    localparam int LEN_CAP   = (MAX_LEN < NUM_BYTES) ? MAX_LEN : NUM_BYTES;

    typedef logic [BYTE_W-1:0]           byte_t;
    typedef byte_t [NUM_BYTES-1:0]       bytes_t;
    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [LEN_W-1:0]            len_t;

    typedef struct packed {
        logic found;
        idx_t pivot;
        idx_t swap;
        len_t len;
    } pivot_info_t;

endpackage
`default_nettype wire

// ===== rtl/np_pivot_find.sv =====
`default_nettype none
module np_pivot_find (
    input  wire np_pkg::bytes_t      bytes,
    input  wire np_pkg::len_t        length,
    output np_pkg::pivot_info_t      info
);

    logic [np_pkg::LEN_W:0]          len_wide;
    np_pkg::len_t                    n;
    logic [np_pkg::NUM_BYTES-1:0]    rise;
    logic [np_pkg::NUM_BYTES-1:0]    above;
    np_pkg::byte_t                   pivot_byte;
    np_pkg::idx_t                    p;
    np_pkg::idx_t                    j;
    logic                            found;

    // Saturate the length to the supported bound
    always_comb begin
        len_wide = {1'b0, length};
        if (len_wide > (np_pkg::LEN_W + 1)'(np_pkg::LEN_CAP)) begin
            n = np_pkg::LEN_W'(np_pkg::LEN_CAP);
        end else begin
            n = length;
        end
    end

    // Rightmost position whose byte is below its right neighbor
    always_comb begin
        rise  = '0;
        found = 1'b0;
        p     = '0;
        for (int k = 0; k < np_pkg::NUM_BYTES - 1; k++) begin
            rise[k] = (np_pkg::LEN_W'(k + 1) < n) && (bytes[k] < bytes[k+1]);
        end
        for (int k = 0; k < np_pkg::NUM_BYTES - 1; k++) begin
            if (rise[k]) begin
                found = 1'b1;
                p     = np_pkg::IDX_W'(k);
            end
        end
    end

    // Rightmost suffix byte greater than the pivot byte
    always_comb begin
        pivot_byte = bytes[p];
        above      = '0;
        j          = p;
        for (int k = 0; k < np_pkg::NUM_BYTES; k++) begin
            above[k] = (np_pkg::IDX_W'(k) > p) && (np_pkg::LEN_W'(k) < n)
                       && (bytes[k] > pivot_byte);
        end
        for (int k = 0; k < np_pkg::NUM_BYTES; k++) begin
            if (above[k]) begin
                j = np_pkg::IDX_W'(k);
            end
        end
    end

    assign info.found = found;
    assign info.pivot = p;
    assign info.swap  = j;
    assign info.len   = n;

endmodule
`default_nettype wire

// ===== rtl/np_rearrange.sv =====
`default_nettype none
module np_rearrange (
    input  wire np_pkg::bytes_t      bytes,
    input  wire np_pkg::pivot_info_t info,
    output np_pkg::bytes_t           result
);

    np_pkg::len_t  mirror [np_pkg::NUM_BYTES];
    np_pkg::idx_t  src    [np_pkg::NUM_BYTES];

    // Swap pivot with the chosen byte, then reverse the suffix after the pivot
    always_comb begin
        for (int k = 0; k < np_pkg::NUM_BYTES; k++) begin
            mirror[k] = {1'b0, info.pivot} + info.len - np_pkg::LEN_W'(k);
            src[k]    = mirror[k][np_pkg::IDX_W-1:0];
            result[k] = bytes[k];
            if (info.found) begin
                if (np_pkg::IDX_W'(k) == info.pivot) begin
                    result[k] = bytes[info.swap];
                end else if (np_pkg::IDX_W'(k) > info.pivot
                             && np_pkg::LEN_W'(k) < info.len) begin
                    if (src[k] == info.swap) begin
                        result[k] = bytes[info.pivot];
                    end else begin
                        result[k] = bytes[src[k]];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/next_permutation_core.sv =====
// next_permutation_core: next lexicographic arrangement of up to eight bytes.
// Throughput: one transfer per cycle; input register, pivot search and
// rearrange logic, then result register, all advancing on downstream ready.
// Reset: aresetn is synchronous, active low, and clears both valid flags.
`default_nettype none
module next_permutation_core (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // char_0 [7:0], char_1 .. char_7 [63:56], length [67:64], zero fill
    input  wire [np_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // out_0 [7:0], out_1 .. out_7 [63:56]
    output logic [np_pkg::M_DATA_W-1:0]   m_tdata,
    // advanced [0]
    output logic                          m_tuser
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    np_pkg::bytes_t        in_bytes_reg;
    np_pkg::len_t          in_len_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    np_pkg::bytes_t        out_bytes_reg;
    logic                  out_adv_reg;
    logic                  out_advance;
    logic                  in_take;
    np_pkg::pivot_info_t   info;
    np_pkg::bytes_t        result;

    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign in_take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_advance) begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_bytes_reg <= s_tdata[np_pkg::M_DATA_W-1:0];
            in_len_reg   <= s_tdata[np_pkg::M_DATA_W +: np_pkg::LEN_W];
        end
        if (out_advance && in_valid_reg) begin
            out_bytes_reg <= result;
            out_adv_reg   <= info.found;
        end
    end

    np_pivot_find u_pivot (
        .bytes  (in_bytes_reg),
        .length (in_len_reg),
        .info   (info)
    );

    np_rearrange u_rearrange (
        .bytes  (in_bytes_reg),
        .info   (info),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bytes_reg;
    assign m_tuser  = out_adv_reg;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_swap_after_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && info.found) |->
            (info.swap > info.pivot && {1'b0, info.swap} < info.len))
        else $error("swap position outside suffix");

    a_no_pivot_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !info.found) |-> (result == in_bytes_reg))
        else $error("bytes changed without a pivot");

    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> in_valid_reg)
        else $error("accepted transfer lost in input stage");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    // Input transfer layout: bytes in the low bits, length above, zero fill on top
    typedef struct packed {
        logic [np_pkg::S_DATA_W-np_pkg::M_DATA_W-np_pkg::LEN_W-1:0] fill;
        np_pkg::len_t                                                len;
        np_pkg::bytes_t                                              chars;
    } perm_req_t;

    typedef struct {
        np_pkg::bytes_t chars;
        logic           advanced;
    } perm_res_t;

    logic                        aclk;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [np_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [np_pkg::M_DATA_W-1:0] m_tdata;
    logic                        m_tuser;

    perm_req_t pending_reqs[$];
    perm_res_t expected_perms[$];

    int  n_sent;
    int  n_checked;
    int  n_advanced;
    int  n_errors;
    int  n_in_stall_cycles;

    int  tx_gap;
    int  tx_run_left;
    bit  tx_no_gaps;
    int  rx_wait;
    int  rx_draw;
    int  rx_run_left;
    bit  rx_no_gaps;
    int  hold_left;
    int  holds_done;
    logic rx_hold;

    next_permutation_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Next arrangement of the first len bytes, unsigned byte order
    function automatic perm_res_t next_arrangement(input perm_req_t req);
        perm_res_t      res;
        np_pkg::bytes_t b;
        int             n;
        int             p;
        int             j;
        int             lo;
        int             hi;
        np_pkg::byte_t  t;
        bit             found;
        b = req.chars;
        n = req.len;
        if (n > np_pkg::LEN_CAP)
            n = np_pkg::LEN_CAP;
        found = 1'b0;
        p = 0;
        for (int k = n - 1; k > 0 && !found; k--) begin
            if (b[k-1] < b[k]) begin
                p = k - 1;
                found = 1'b1;
            end
        end
        if (found) begin
            j = n - 1;
            while (j > p && b[j] <= b[p])
                j--;
            t = b[p];
            b[p] = b[j];
            b[j] = t;
            lo = p + 1;
            hi = n - 1;
            while (lo < hi) begin
                t = b[lo];
                b[lo] = b[hi];
                b[hi] = t;
                lo++;
                hi--;
            end
        end
        res.chars = b;
        res.advanced = found;
        return res;
    endfunction

    function automatic perm_req_t pack_req(input int len,
                                           input np_pkg::byte_t c0, input np_pkg::byte_t c1,
                                           input np_pkg::byte_t c2, input np_pkg::byte_t c3,
                                           input np_pkg::byte_t c4, input np_pkg::byte_t c5,
                                           input np_pkg::byte_t c6, input np_pkg::byte_t c7);
        perm_req_t req;
        req = '0;
        req.len = np_pkg::len_t'(len);
        req.chars = {c7, c6, c5, c4, c3, c2, c1, c0};
        return req;
    endfunction

    // Append to the tail of the pending queue
    function automatic void enqueue_req(input perm_req_t req);
        pending_reqs.insert(pending_reqs.size(), req);
    endfunction

    // Values from a three-wide window, so repeats are common
    function automatic np_pkg::bytes_t small_alphabet_bytes();
        np_pkg::bytes_t b;
        int             base;
        base = $urandom_range(0, 253);
        for (int k = 0; k < np_pkg::NUM_BYTES; k++)
            b[k] = np_pkg::byte_t'(base + $urandom_range(0, 2));
        return b;
    endfunction

    // Per-item wait; each run of items is drawn as either gap-free or gappy
    function automatic int draw_wait(inout int run_left, inout bit no_gaps);
        if (run_left == 0) begin
            run_left = $urandom_range(5, 40);
            no_gaps = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return no_gaps ? 0 : $urandom_range(0, 13);
    endfunction

    // Sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_perms.insert(expected_perms.size(),
                                      next_arrangement(perm_req_t'(s_tdata)));
                n_sent++;
            end
            if (s_tvalid && !s_tready)
                n_in_stall_cycles++;
            if (!s_tvalid || s_tready) begin
                // keep offering while the receiver is held off
                if (tx_gap != 0 && !rx_hold) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    s_tdata <= pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    tx_gap <= draw_wait(tx_run_left, tx_no_gaps);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs to fill the pipeline and stall the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && n_checked >= 120) ||
                     (holds_done == 1 && n_checked >= 400)) begin
            hold_left <= 60;
            holds_done <= holds_done + 1;
        end
    end

    assign rx_hold = (hold_left != 0);

    // Receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            rx_draw = 0;
            if (m_tvalid && m_tready) begin
                if (expected_perms.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: got %h adv %b",
                             $time, m_tdata, m_tuser);
                    n_errors++;
                end else begin
                    perm_res_t      exp_res;
                    np_pkg::bytes_t got;
                    exp_res = expected_perms.pop_front();
                    got = m_tdata;
                    for (int k = 0; k < np_pkg::NUM_BYTES; k++) begin
                        if (got[k] !== exp_res.chars[k]) begin
                            $display("%0t: out_%0d mismatch: expected %h, actual %h",
                                     $time, k, exp_res.chars[k], got[k]);
                            n_errors++;
                        end
                    end
                    if (m_tuser !== exp_res.advanced) begin
                        $display("%0t: advanced mismatch: expected %b, actual %b",
                                 $time, exp_res.advanced, m_tuser);
                        n_errors++;
                    end
                    if (exp_res.advanced)
                        n_advanced++;
                end
                n_checked++;
                rx_draw = draw_wait(rx_run_left, rx_no_gaps);
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                if (rx_draw == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_wait <= rx_draw - 1;
                end
            end else if (!m_tready) begin
                if (rx_wait == 0)
                    m_tready <= 1'b1;
                else
                    rx_wait <= rx_wait - 1;
            end
        end
    end

    initial begin
        perm_req_t req;
        perm_req_t chain;
        perm_res_t res;
        bit        chain_live;
        int        pick;
        int        v;

        // Directed: short strings, extremes, repeats, no successor, saturation
        enqueue_req(pack_req(0, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01, 8'h00, 8'hff, 8'h80));
        enqueue_req(pack_req(1, 8'h01, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03));
        enqueue_req(pack_req(2, 8'h01, 8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        enqueue_req(pack_req(2, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        enqueue_req(pack_req(2, 8'h33, 8'h33, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05));
        enqueue_req(pack_req(8, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07));
        enqueue_req(pack_req(8, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01, 8'h00));
        enqueue_req(pack_req(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        enqueue_req(pack_req(8, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        enqueue_req(pack_req(8, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff));
        enqueue_req(pack_req(4, 8'h01, 8'h01, 8'h02, 8'h02, 8'haa, 8'h55, 8'haa, 8'h55));
        enqueue_req(pack_req(5, 8'h03, 8'h03, 8'h02, 8'h01, 8'h01, 8'h77, 8'h88, 8'h99));
        enqueue_req(pack_req(8, 8'h01, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02));
        enqueue_req(pack_req(9, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07));
        enqueue_req(pack_req(15, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03, 8'h02, 8'h01));
        enqueue_req(pack_req(12, 8'h10, 8'h20, 8'h20, 8'h10, 8'h30, 8'h30, 8'h20, 8'h10));
        enqueue_req(pack_req(3, 8'h03, 8'h02, 8'h01, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff));
        enqueue_req(pack_req(2, 8'h7f, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        enqueue_req(pack_req(2, 8'h80, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        enqueue_req(pack_req(5, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h01, 8'h02, 8'h03));
        enqueue_req(pack_req(7, 8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h03, 8'h02, 8'h01));
        enqueue_req(pack_req(6, 8'h05, 8'h01, 8'h04, 8'h03, 8'h02, 8'h01, 8'hc3, 8'h3c));

        // Random: walks through successive arrangements mixed with fresh strings
        chain_live = 1'b0;
        chain = '0;
        for (int i = 0; i < 650; i++) begin
            pick = $urandom_range(0, 99);
            req = '0;
            if (pick < 35) begin
                if (!chain_live) begin
                    chain = '0;
                    chain.len = np_pkg::len_t'($urandom_range(3, 6));
                    chain.chars = small_alphabet_bytes();
                    chain_live = 1'b1;
                end
                req = chain;
                res = next_arrangement(chain);
                chain.chars = res.chars;
                chain_live = res.advanced;
            end else begin
                v = $urandom_range(0, 99);
                if (v < 10)
                    req.len = np_pkg::len_t'($urandom_range(0, 1));
                else if (v < 22)
                    req.len = np_pkg::len_t'($urandom_range(9, 15));
                else
                    req.len = np_pkg::len_t'($urandom_range(2, 8));
                if (pick < 60) begin
                    req.chars = small_alphabet_bytes();
                end else if (pick < 88) begin
                    for (int k = 0; k < np_pkg::NUM_BYTES; k++)
                        req.chars[k] = np_pkg::byte_t'($urandom_range(0, 255));
                end else begin
                    // non-increasing run, no successor
                    v = $urandom_range(0, 255);
                    for (int k = 0; k < np_pkg::NUM_BYTES; k++) begin
                        req.chars[k] = np_pkg::byte_t'(v);
                        v = v - $urandom_range(0, (v < 3) ? v : 3);
                    end
                end
            end
            enqueue_req(req);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_perms.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d strings, checked %0d results (%0d advanced, %0d unchanged).",
                 n_sent, n_checked, n_advanced, n_checked - n_advanced);
        $display("Input stalled for %0d cycles across %0d receiver hold-offs.",
                 n_in_stall_cycles, holds_done);
        if (n_errors == 0)
            $display("** next_permutation_core: PASSED **");
        else
            $display("** next_permutation_core: FAILED **");
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Timeout: %0d results still expected", expected_perms.size());
        $display("** next_permutation_core: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/np_pkg.sv
rtl/np_pivot_find.sv
rtl/np_rearrange.sv
rtl/next_permutation_core.sv
dv/tb_top.sv
